// ===== hdl/ptpwm_pkg.sv =====
`timescale 1ns / 1ps

package ptpwm_pkg;

  localparam int unsigned MaxChannels = 3;
  localparam int unsigned CtrlW       = 7;
  localparam int unsigned DataW       = 8;
  localparam int unsigned IdxW        = 3;
  localparam int unsigned PreW        = 5;
  localparam int unsigned PostW       = 4;

  // timer_control bit layout
  localparam int unsigned CtrlPs4Bit  = 0;
  localparam int unsigned CtrlPs16Bit = 1;
  localparam int unsigned CtrlEnBit   = 2;
  localparam int unsigned CtrlPostLsb = 3;
  localparam int unsigned CtrlPostMsb = 6;

  localparam logic [PreW-1:0]  PreLimit16 = PreW'(16);
  localparam logic [PreW-1:0]  PreLimit4  = PreW'(4);
  localparam logic [PreW-1:0]  PreLimit1  = PreW'(1);
  localparam logic [DataW-1:0] PeriodRst  = 8'hFF;

  typedef enum logic [IdxW-1:0] {
    RegCtrl   = 3'd0,
    RegPeriod = 3'd1,
    RegPwmEn  = 3'd2,
    RegDuty1  = 3'd3,
    RegDuty2  = 3'd4,
    RegDuty3  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [CtrlW-1:0]                  ctrl;
    logic [DataW-1:0]                  period;
    logic [MaxChannels-1:0]            pwm_en;
    logic [MaxChannels-1:0][DataW-1:0] duty;
  } cfg_t;

endpackage

// ===== hdl/ptpwm_cfg_regs.sv =====
`timescale 1ns / 1ps

module ptpwm_cfg_regs #(
  parameter int unsigned Channels = ptpwm_pkg::MaxChannels
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_i,
  input  logic [ptpwm_pkg::IdxW-1:0]  idx_i,
  input  logic [ptpwm_pkg::DataW-1:0] data_i,
  output ptpwm_pkg::cfg_t             cfg_o
);
  import ptpwm_pkg::*;

  logic [CtrlW-1:0]    ctrl_q;
  logic [DataW-1:0]    period_q;
  logic [Channels-1:0] pwm_en_q;
  reg_idx_e            idx;

  assign idx = reg_idx_e'(idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q   <= '0;
      period_q <= PeriodRst;
      pwm_en_q <= '0;
    end else if (wr_i) begin
      unique case (idx)
        RegCtrl:   ctrl_q   <= data_i[CtrlW-1:0];
        RegPeriod: period_q <= data_i;
        RegPwmEn:  pwm_en_q <= data_i[Channels-1:0];
        default:   ;
      endcase
    end
  end

  assign cfg_o.ctrl   = ctrl_q;
  assign cfg_o.period = period_q;

  for (genvar k = 0; k < MaxChannels; k++) begin : g_chan
    if (k < Channels) begin : g_on
      logic [DataW-1:0] duty_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          duty_q <= '0;
        end else if (wr_i && (idx_i == IdxW'(RegDuty1) + IdxW'(k))) begin
          duty_q <= data_i;
        end
      end
      assign cfg_o.duty[k]   = duty_q;
      assign cfg_o.pwm_en[k] = pwm_en_q[k];
    end else begin : g_off
      assign cfg_o.duty[k]   = '0;
      assign cfg_o.pwm_en[k] = 1'b0;
    end
  end

endmodule

// ===== hdl/ptpwm_core.sv =====
`timescale 1ns / 1ps

module ptpwm_core #(
  parameter int unsigned Channels = ptpwm_pkg::MaxChannels
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic                              tick_i,
  input  ptpwm_pkg::cfg_t                   cfg_i,
  output logic [ptpwm_pkg::DataW-1:0]       timer_value_o,
  output logic                              period_event_o,
  output logic [ptpwm_pkg::MaxChannels-1:0] pwm_pins_o
);
  import ptpwm_pkg::*;

  logic [DataW-1:0]                count_q, count_d, cnt_inc;
  logic [PreW-1:0]                 pre_q, pre_d, pre_inc, limit;
  logic [PostW-1:0]                post_q, post_d;
  logic [PostW:0]                  post_inc, post_limit;
  logic [Channels-1:0][DataW-1:0]  latch_q, latch_d;
  logic [Channels-1:0]             pin_q, pin_d;
  logic                            en, fire, match, expire;
  logic [MaxChannels-1:0]          pins_full;

  logic [DataW-1:0]       res_value_q;
  logic                   res_event_q;
  logic [MaxChannels-1:0] res_pins_q;

  always_comb begin
    en = tick_i & cfg_i.ctrl[CtrlEnBit];
    if (cfg_i.ctrl[CtrlPs16Bit]) begin
      limit = PreLimit16;
    end else if (cfg_i.ctrl[CtrlPs4Bit]) begin
      limit = PreLimit4;
    end else begin
      limit = PreLimit1;
    end
    pre_inc    = pre_q + PreW'(1);
    fire       = en && (pre_inc >= limit);
    cnt_inc    = count_q + DataW'(1);
    match      = fire && (cnt_inc == cfg_i.period);
    post_inc   = {1'b0, post_q} + (PostW+1)'(1);
    post_limit = {1'b0, cfg_i.ctrl[CtrlPostMsb:CtrlPostLsb]} + (PostW+1)'(1);
    expire     = match && (post_inc >= post_limit);

    pre_d   = pre_q;
    count_d = count_q;
    post_d  = post_q;
    latch_d = latch_q;
    pin_d   = pin_q;

    if (en) begin
      pre_d = fire ? '0 : pre_inc;
    end
    if (fire) begin
      count_d = match ? '0 : cnt_inc;
    end
    if (match) begin
      post_d = expire ? '0 : post_inc[PostW-1:0];
    end
    // Set at the match first, then compare against the new count.
    for (int i = 0; i < Channels; i++) begin
      if (match && cfg_i.pwm_en[i]) begin
        latch_d[i] = cfg_i.duty[i];
        pin_d[i]   = 1'b1;
      end
      if (en && cfg_i.pwm_en[i] && (count_d >= latch_d[i])) begin
        pin_d[i] = 1'b0;
      end
    end
  end

  for (genvar k = 0; k < MaxChannels; k++) begin : g_pins
    if (k < Channels) begin : g_on
      assign pins_full[k] = pin_d[k];
    end else begin : g_off
      assign pins_full[k] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pre_q   <= '0;
      post_q  <= '0;
      latch_q <= '0;
      pin_q   <= '0;
    end else if (step_i) begin
      count_q <= count_d;
      pre_q   <= pre_d;
      post_q  <= post_d;
      latch_q <= latch_d;
      pin_q   <= pin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_value_q <= count_d;
      res_event_q <= expire;
      res_pins_q  <= pins_full;
    end
  end

  assign timer_value_o  = res_value_q;
  assign period_event_o = res_event_q;
  assign pwm_pins_o     = res_pins_q;

endmodule

// ===== hdl/period_timer_with_pwm_top.sv =====
`timescale 1ns / 1ps

// Period timer with prescaler, postscaler and up to three PWM channels.
//
// Input channel (in_valid_i / in_ready_o / tick_i): one transaction per
// instruction-cycle slot; tick_i = 1 lets a timer tick elapse, tick_i = 0
// leaves all state alone but still yields a result.
// Output channel (out_valid_o / out_ready_i): exactly one result transaction
// per input transaction, in order: timer count after the tick, a period
// event flag set when the postscaler expires, and the PWM pin levels.
// Configuration channel (cfg_valid_i / cfg_ready_o): register index and data;
// always ready. Write only while the block is idle.
//
// From input acceptance to out_valid_o a transaction passes one input
// register, then the timer update that lands in the result register.
// Throughput is one transaction per cycle while out_ready_i holds; the
// timer state loop is a single 8-bit increment and compare per cycle.
// A stalled receiver holds the result register; the input register still
// takes one more transaction, after which in_ready_o drops until the
// output drains. Reset clears the timer, prescaler, postscaler, latched
// duties, pins, the configuration registers (period resets to 255) and
// both valid flags.
module period_timer_with_pwm_top #(
  parameter int unsigned Channels = ptpwm_pkg::MaxChannels
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              tick_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ptpwm_pkg::DataW-1:0]       timer_value_o,
  output logic                              period_event_o,
  output logic [ptpwm_pkg::MaxChannels-1:0] pwm_pins_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ptpwm_pkg::IdxW-1:0]        cfg_index_i,
  input  logic [ptpwm_pkg::DataW-1:0]       cfg_data_i
);
  import ptpwm_pkg::*;

  cfg_t cfg;
  logic s1_valid_q, s1_tick_q, out_valid_q;
  logic adv_out, step;

  // Configuration writes never stall.
  assign cfg_ready_o = 1'b1;

  ptpwm_cfg_regs #(
    .Channels(Channels)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_valid_i),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // Result register can load when empty or being drained this cycle.
  assign adv_out    = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && adv_out;
  assign in_ready_o = !s1_valid_q || adv_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv_out) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Hold the tick in the input register until the core takes it.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_tick_q <= tick_i;
    end
  end

  ptpwm_core #(
    .Channels(Channels)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .tick_i         (s1_tick_q),
    .cfg_i          (cfg),
    .timer_value_o  (timer_value_o),
    .period_event_o (period_event_o),
    .pwm_pins_o     (pwm_pins_o)
  );

  assign out_valid_o = out_valid_q;

  // A period event always comes from a match, which returns the count to 0.
  a_event_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && period_event_o) |-> (timer_value_o == '0))
    else $error("period event with nonzero timer value");

  // Backpressure at the input only when both stages are full and stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_o && !out_ready_i))
    else $error("input stalled without a full, stalled pipeline");

  // A stepped item shows up as a valid result on the next cycle.
  a_step_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("stepped item did not reach the result register");

endmodule

// ===== bench/period_timer_with_pwm_top_tb.sv =====
`timescale 1ns / 1ps

module period_timer_with_pwm_top_tb;
  import ptpwm_pkg::*;

  localparam int unsigned NumChannels  = MaxChannels;
  // Margin after the last result: hold off this long before a register write.
  localparam int unsigned SettleCycles = 4;
  // Cycles without any transaction on any channel before the run is abandoned.
  localparam int unsigned StallLimit   = 2000;
  // Enabled ticks to send during the random settings phases.
  localparam int unsigned RandomTicks  = 730;
  // Ticks for the period-zero phase: enough for the count to wrap at least once.
  localparam int unsigned WrapTicks    = 320;

  // Register indexes past the last duty register; the block must ignore them.
  localparam logic [IdxW-1:0] RegSpareLo = IdxW'(int'(RegDuty3) + 1);
  localparam logic [IdxW-1:0] RegSpareHi = '1;

  // Prescale select as written into timer_control bits 1..0 (bit 1 wins).
  typedef enum logic [1:0] {
    Div1      = 2'b00,
    Div4      = 2'b01,
    Div16     = 2'b10,
    Div16Both = 2'b11
  } prescale_e;

  typedef struct packed {
    logic [DataW-1:0]       count;
    logic                   period_hit;
    logic [NumChannels-1:0] pins;
  } timer_result_t;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  logic                   tick        = 1'b0;
  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  logic [DataW-1:0]       timer_value;
  logic                   period_event;
  logic [NumChannels-1:0] pwm_pins;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [IdxW-1:0]        cfg_index   = '0;
  logic [DataW-1:0]       cfg_data    = '0;

  // Register copies and timer state of the predictor.
  logic [CtrlW-1:0]       tmr_ctrl;
  logic [DataW-1:0]       tmr_period;
  logic [NumChannels-1:0] pwm_mask;
  logic [DataW-1:0]       duty_set  [NumChannels];
  logic [DataW-1:0]       tmr_count;
  logic [PreW-1:0]        pre_count;
  logic [PostW-1:0]       post_count;
  logic [DataW-1:0]       duty_held [NumChannels];
  logic [NumChannels-1:0] pin_state;

  timer_result_t pending_results[$];
  int unsigned   mismatches   = 0;
  int unsigned   quiet_cycles = 0;
  bit            steady_input = 1'b0;

  period_timer_with_pwm_top u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .tick_i         (tick),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .timer_value_o  (timer_value),
    .period_event_o (period_event),
    .pwm_pins_o     (pwm_pins),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Build a timer_control value from its fields.
  function automatic logic [CtrlW-1:0] ctrl_word(logic en, prescale_e div,
                                                 logic [PostW-1:0] post_m1);
    logic [CtrlW-1:0] w;
    logic [1:0]       sel;
    sel                        = div;
    w                          = '0;
    w[CtrlEnBit]               = en;
    w[CtrlPs16Bit]             = sel[1];
    w[CtrlPs4Bit]              = sel[0];
    w[CtrlPostMsb:CtrlPostLsb] = post_m1;
    return w;
  endfunction

  // Mostly back-to-back, sometimes a short gap, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Advance the predicted timer by one input transaction and return what the
  // block must report for it.
  function automatic timer_result_t advance_timer(logic tick_in);
    timer_result_t r;
    int            pre_next;
    int            post_next;
    int            div_limit;
    r.period_hit = 1'b0;
    if (tick_in && tmr_ctrl[CtrlEnBit]) begin
      if (tmr_ctrl[CtrlPs16Bit]) div_limit = 16;
      else if (tmr_ctrl[CtrlPs4Bit]) div_limit = 4;
      else div_limit = 1;
      // A lowered prescale fires as soon as the counter reaches it.
      pre_next = int'(pre_count) + 1;
      if (pre_next >= div_limit) begin
        tmr_count = tmr_count + 1'b1;
        if (tmr_count == tmr_period) begin
          tmr_count = '0;
          post_next = int'(post_count) + 1;
          if (post_next >= int'(tmr_ctrl[CtrlPostMsb:CtrlPostLsb]) + 1) begin
            r.period_hit = 1'b1;
            post_next    = 0;
          end
          post_count = PostW'(post_next);
          // Set first: latch the duty and raise the pin of each enabled channel.
          for (int ch = 0; ch < NumChannels; ch++) begin
            if (pwm_mask[ch]) begin
              duty_held[ch] = duty_set[ch];
              pin_state[ch] = 1'b1;
            end
          end
        end
        pre_next = 0;
      end
      pre_count = PreW'(pre_next);
      // Then compare: drop the pin once the count reaches the latched duty.
      for (int ch = 0; ch < NumChannels; ch++) begin
        if (pwm_mask[ch] && tmr_count >= duty_held[ch]) pin_state[ch] = 1'b0;
      end
    end
    r.count = tmr_count;
    r.pins  = pin_state;
    return r;
  endfunction

  // Send one tick transaction after an optional gap and record its expected result.
  // Valid stays high on return so a following send can go back-to-back.
  task automatic send_tick(input logic tick_in);
    int unsigned gap;
    gap = steady_input ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick     <= tick_in;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(advance_timer(tick_in));
  endtask

  // Hold the input side until every expected result has come, then let the
  // pipeline settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // One configuration transaction; the caller drops cfg_valid after the last one.
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegCtrl:   tmr_ctrl    = data[CtrlW-1:0];
      RegPeriod: tmr_period  = data;
      RegPwmEn:  pwm_mask    = data[NumChannels-1:0];
      RegDuty1:  duty_set[0] = data;
      RegDuty2:  duty_set[1] = data;
      RegDuty3:  duty_set[2] = data;
      default: ;
    endcase
  endtask

  // Drain, then rewrite every register. Now and then also hit an unused index.
  task automatic program_timer(input logic [DataW-1:0] ctrl_raw, input logic [DataW-1:0] per,
                               input logic [DataW-1:0] pwm_raw, input logic [DataW-1:0] d0,
                               input logic [DataW-1:0] d1, input logic [DataW-1:0] d2);
    drain_results();
    write_reg(RegCtrl, ctrl_raw);
    write_reg(RegPeriod, per);
    write_reg(RegPwmEn, pwm_raw);
    write_reg(RegDuty1, d0);
    write_reg(RegDuty2, d1);
    write_reg(RegDuty3, d2);
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? RegSpareLo : RegSpareHi, DataW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Duty at most one above the period most of the time, so pins toggle within each period.
  function automatic logic [DataW-1:0] pick_duty(logic [DataW-1:0] per);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    if (per == '0 || per == '1) return DataW'($urandom);
    return DataW'($urandom_range(int'(per) + 1));
  endfunction

  // Reset configuration: the timer is off, so ticks change nothing.
  task automatic test_idle_after_reset();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Out-of-range bits in control and enable are dropped; both prescale bits
  // set selects divide by 16, with a postscale of 16.
  task automatic test_register_masking();
    program_timer('1, 8'd2, '1, 8'd1, 8'd0, 8'd2);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // Short period, no prescale or postscale: event on every match, duty of
  // zero never shows a high pin, duty of 255 never drops it.
  task automatic test_pwm_basic();
    program_timer(DataW'(ctrl_word(1'b1, Div1, '0)), 8'd3, 8'd7, 8'd0, 8'd2, 8'd255);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  // Switch from divide by 16 to divide by 4 with the prescaler already past 4.
  task automatic test_prescale_change();
    program_timer(DataW'(ctrl_word(1'b1, Div16, '0)), 8'd3, 8'd7, 8'd1, 8'd2, 8'd3);
    repeat (5) send_tick(1'b1);
    program_timer(DataW'(ctrl_word(1'b1, Div4, '0)), 8'd3, 8'd7, 8'd1, 8'd2, 8'd3);
    repeat (2) send_tick(1'b1);
  endtask

  // Period of one matches on every tick. Lower the postscale below the
  // matches already counted, and disable a channel whose pin is high.
  task automatic test_postscale_lower();
    program_timer(DataW'(ctrl_word(1'b1, Div1, 4'd15)), 8'd1, 8'd7, 8'd0, 8'd1, 8'd255);
    repeat (4) send_tick(1'b1);
    program_timer(DataW'(ctrl_word(1'b1, Div1, 4'd1)), 8'd1, 8'd5, 8'd0, 8'd1, 8'd255);
    repeat (2) send_tick(1'b1);
  endtask

  // Period zero: a match only when the count wraps from 255.
  task automatic test_period_wrap();
    program_timer(DataW'(ctrl_word(1'b1, Div1, 4'($urandom_range(3)))), 8'd0, 8'd7,
                  8'd255, DataW'($urandom), 8'd128);
    for (int i = 0; i < WrapTicks; i++) send_tick($urandom_range(19) != 0);
  endtask

  // Random settings phases; timer state carries over from phase to phase.
  task automatic test_random_settings();
    int unsigned      sent;
    int unsigned      n;
    int unsigned      roll;
    prescale_e        div;
    logic [DataW-1:0] per;
    logic [PostW-1:0] post;
    logic             en;
    logic             t;
    sent = 0;
    while (sent < RandomTicks) begin
      roll = $urandom_range(9);
      if (roll < 6) div = Div1;
      else if (roll < 8) div = Div4;
      else if (roll == 8) div = Div16;
      else div = Div16Both;

      roll = $urandom_range(99);
      if (div == Div16 || div == Div16Both) per = DataW'($urandom_range(6, 1));
      else if (roll < 8) per = '0;
      else if (roll < 16 && div == Div1) per = '1;
      else if (div == Div4) per = DataW'($urandom_range(8, 1));
      else per = DataW'($urandom_range(24, 1));

      roll = $urandom_range(99);
      if (roll < 15) post = '0;
      else if (roll < 30) post = '1;
      else post = PostW'($urandom);

      en = ($urandom_range(9) != 0);
      program_timer({1'($urandom), ctrl_word(en, div, post)}, per,
                    DataW'($urandom) | ($urandom_range(1) ? 8'h07 : 8'h00),
                    pick_duty(per), pick_duty(per), pick_duty(per));

      // Some phases run with no input gaps at all.
      steady_input = ($urandom_range(4) == 0);
      n = $urandom_range(90, 20);
      for (int i = 0; i < n; i++) begin
        t = ($urandom_range(9) != 0);
        send_tick(t);
        if (t && en) sent++;
      end
      steady_input = 1'b0;
    end
  endtask

  // Receiver: drop ready for random stretches, with ready runs between, now and then long ones.
  initial begin : result_sink
    int unsigned hold;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat (($urandom_range(99) < 15) ? $urandom_range(60, 20) : $urandom_range(6, 1))
        @(posedge clk);
    end
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin : result_check
    timer_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: timer_value=%0d period_event=%0b pins=%b",
                 $time, timer_value, period_event, pwm_pins);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (timer_value !== want.count) begin
          $display("%0t: timer_value expected %0d got %0d", $time, want.count, timer_value);
          mismatches++;
        end
        if (period_event !== want.period_hit) begin
          $display("%0t: period_event expected %0b got %0b", $time, want.period_hit,
                   period_event);
          mismatches++;
        end
        if (pwm_pins !== want.pins) begin
          $display("%0t: pwm_pins expected %b got %b", $time, want.pins, pwm_pins);
          mismatches++;
        end
      end
    end
  end

  // Abort when no channel moves a transaction for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                 StallLimit, pending_results.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    // Predictor starts from the reset state of the block.
    tmr_ctrl   = '0;
    tmr_period = PeriodRst;
    pwm_mask   = '0;
    tmr_count  = '0;
    pre_count  = '0;
    post_count = '0;
    pin_state  = '0;
    for (int ch = 0; ch < NumChannels; ch++) begin
      duty_set[ch]  = '0;
      duty_held[ch] = '0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_after_reset();
    test_register_masking();
    test_pwm_basic();
    test_prescale_change();
    test_postscale_lower();
    test_period_wrap();
    test_random_settings();
    drain_results();

    if (mismatches == 0 && pending_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
